[src/bounded_ordered_list_store_core_defines.svh]
// Assertion macros used by the list store core RTL.
`ifndef BOUNDED_ORDERED_LIST_STORE_CORE_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_STORE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define BOLS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define BOLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BOLS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define BOLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[src/bols_pkg.sv]
`default_nettype none

package bols_pkg;

    // Port field widths.
    localparam int OP_W      = 3;
    localparam int IO_VAL_W  = 32;
    localparam int POS_W     = 4;
    localparam int STAT_W    = 2;
    localparam int OUT_CNT_W = 5;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_APPEND   = 3'd0;
    localparam logic [OP_W-1:0] OP_ERASE    = 3'd1;
    localparam logic [OP_W-1:0] OP_SET      = 3'd2;
    localparam logic [OP_W-1:0] OP_COUNT    = 3'd3;
    localparam logic [OP_W-1:0] OP_CONTAINS = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd5;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISS  = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

endpackage

`default_nettype wire

[src/bols_ram.sv]
`default_nettype none

module bols_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[src/bounded_ordered_list_store_core.sv]
`default_nettype none
`include "bounded_ordered_list_store_core_defines.svh"

// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+-----------------------------------------
// in       | input     | in_valid / in_stall | op, item_value, position
// out      | output    | out_valid/out_stall | status, match_count, found, list_length,
//          |           |                     | head_value, tail_value, is_empty
//
// Append, set, clear and unused ops load the result straight after execution; count and
// contains on a non-empty list read each entry through the one read port and comparator, erase
// reads up to its first match; a successful erase then closes the gap one entry per cycle.
// Reset clears the fill count and all registers; the entry memory is not swept.
// in_stall is high from acceptance until the result is loaded, so the next item can be taken
// in the cycle after the load; a stalled output holds its result while the next waits finished.

module bounded_ordered_list_store_core #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [bols_pkg::OP_W-1:0]        op,
    input  logic [bols_pkg::IO_VAL_W-1:0]    item_value,
    input  logic [bols_pkg::POS_W-1:0]       position,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [bols_pkg::STAT_W-1:0]      status,
    output logic [bols_pkg::OUT_CNT_W-1:0]   match_count,
    output logic                             found,
    output logic [bols_pkg::OUT_CNT_W-1:0]   list_length,
    output logic [bols_pkg::IO_VAL_W-1:0]    head_value,
    output logic [bols_pkg::IO_VAL_W-1:0]    tail_value,
    output logic                             is_empty
);

    import bols_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SHIFT,
        S_RDHEAD,
        S_RDTAIL,
        S_CAPTAIL,
        S_FIN
    } state_t;

    state_t                  state_reg, state_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic [VALUE_WIDTH-1:0]  val_reg, val_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [CW-1:0]           fill_reg, fill_next;
    logic [VALUE_WIDTH-1:0]  head_reg, head_next;
    logic [VALUE_WIDTH-1:0]  tail_reg, tail_next;
    logic [CW-1:0]           addr_reg, addr_next;
    logic [AW-1:0]           rd_idx_reg, rd_idx_next;
    logic                    rd_pend_reg, rd_pend_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    found_reg, found_next;
    logic [STAT_W-1:0]       stat_reg, stat_next;

    logic                    out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]       res_status_reg, res_status_next;
    logic [OUT_CNT_W-1:0]    res_count_reg, res_count_next;
    logic                    res_found_reg, res_found_next;
    logic [OUT_CNT_W-1:0]    res_length_reg, res_length_next;
    logic [IO_VAL_W-1:0]     res_head_reg, res_head_next;
    logic [IO_VAL_W-1:0]     res_tail_reg, res_tail_next;
    logic                    res_empty_reg, res_empty_next;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [VALUE_WIDTH-1:0]  mem_wdata;
    logic [AW-1:0]           mem_raddr;
    logic [VALUE_WIDTH-1:0]  mem_rdata;

    logic [CW-1:0]           fill_m1;
    logic                    pos_ok;
    logic                    hit;

    bols_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign fill_m1 = fill_reg - CW'(1);
    assign pos_ok  = CMP_W'(pos_reg) < CMP_W'(fill_reg);
    assign hit     = rd_pend_reg && (mem_rdata == val_reg);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        pos_next        = pos_reg;
        fill_next       = fill_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        addr_next       = addr_reg;
        rd_idx_next     = rd_idx_reg;
        rd_pend_next    = 1'b0;
        cnt_next        = cnt_reg;
        found_next      = found_reg;
        stat_next       = stat_reg;
        out_valid_next  = out_valid_reg && out_stall;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        res_found_next  = res_found_reg;
        res_length_next = res_length_reg;
        res_head_next   = res_head_reg;
        res_tail_next   = res_tail_reg;
        res_empty_next  = res_empty_reg;
        mem_we          = 1'b0;
        mem_waddr       = fill_reg[AW-1:0];
        mem_wdata       = val_reg;
        mem_raddr       = addr_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    val_next   = VALUE_WIDTH'(item_value);
                    pos_next   = position;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                stat_next  = ST_OK;
                cnt_next   = '0;
                found_next = 1'b0;
                addr_next  = '0;
                state_next = S_FIN;
                case (op_reg)
                    OP_APPEND:
                    begin
                        if (fill_reg == CW'(DEPTH))
                        begin
                            stat_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = fill_reg[AW-1:0];
                            fill_next = fill_reg + CW'(1);
                            tail_next = val_reg;
                            if (fill_reg == '0)
                            begin
                                head_next = val_reg;
                            end
                        end
                    end
                    OP_SET:
                    begin
                        if (pos_ok)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(pos_reg);
                            if (pos_reg == '0)
                            begin
                                head_next = val_reg;
                            end
                            if (CMP_W'(pos_reg) == CMP_W'(fill_m1))
                            begin
                                tail_next = val_reg;
                            end
                        end
                        else
                        begin
                            stat_next = ST_MISS;
                        end
                    end
                    OP_ERASE, OP_COUNT, OP_CONTAINS:
                    begin
                        if (fill_reg == '0)
                        begin
                            stat_next = ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    OP_CLEAR:
                    begin
                        fill_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_SCAN:
            begin
                if (op_reg == OP_ERASE && hit)
                begin
                    found_next = 1'b1;
                    addr_next  = CW'(rd_idx_reg) + CW'(1);
                    state_next = S_SHIFT;
                end
                else
                begin
                    if (hit)
                    begin
                        cnt_next   = cnt_reg + CW'(1);
                        found_next = 1'b1;
                    end
                    if (addr_reg != fill_reg)
                    begin
                        mem_raddr    = addr_reg[AW-1:0];
                        rd_idx_next  = addr_reg[AW-1:0];
                        rd_pend_next = 1'b1;
                        addr_next    = addr_reg + CW'(1);
                    end
                    else if (!rd_pend_reg)
                    begin
                        // The whole list was read; an erase that reaches here found no match.
                        if (op_reg == OP_ERASE)
                        begin
                            stat_next = ST_MISS;
                        end
                        state_next = S_FIN;
                    end
                end
            end

            S_SHIFT:
            begin
                // Each entry read in the previous cycle moves down by one place.
                if (rd_pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rd_idx_reg - AW'(1);
                    mem_wdata = mem_rdata;
                end
                if (addr_reg != fill_reg)
                begin
                    mem_raddr    = addr_reg[AW-1:0];
                    rd_idx_next  = addr_reg[AW-1:0];
                    rd_pend_next = 1'b1;
                    addr_next    = addr_reg + CW'(1);
                end
                else if (!rd_pend_reg)
                begin
                    fill_next  = fill_m1;
                    state_next = S_RDHEAD;
                end
            end

            S_RDHEAD:
            begin
                mem_raddr  = '0;
                state_next = (fill_reg == '0) ? S_FIN : S_RDTAIL;
            end

            S_RDTAIL:
            begin
                head_next  = mem_rdata;
                mem_raddr  = fill_m1[AW-1:0];
                state_next = S_CAPTAIL;
            end

            S_CAPTAIL:
            begin
                tail_next  = mem_rdata;
                state_next = S_FIN;
            end

            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    res_status_next = stat_reg;
                    res_count_next  = (op_reg == OP_COUNT) ? OUT_CNT_W'(cnt_reg) : '0;
                    res_found_next  = found_reg;
                    res_length_next = OUT_CNT_W'(fill_reg);
                    res_empty_next  = (fill_reg == '0);
                    res_head_next   = (fill_reg == '0) ? '0 : IO_VAL_W'(head_reg);
                    res_tail_next   = (fill_reg == '0) ? '0 : IO_VAL_W'(tail_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= '0;
            val_reg        <= '0;
            pos_reg        <= '0;
            fill_reg       <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            addr_reg       <= '0;
            rd_idx_reg     <= '0;
            rd_pend_reg    <= 1'b0;
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
            stat_reg       <= ST_OK;
            out_valid_reg  <= 1'b0;
            res_status_reg <= ST_OK;
            res_count_reg  <= '0;
            res_found_reg  <= 1'b0;
            res_length_reg <= '0;
            res_head_reg   <= '0;
            res_tail_reg   <= '0;
            res_empty_reg  <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            val_reg        <= val_next;
            pos_reg        <= pos_next;
            fill_reg       <= fill_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            addr_reg       <= addr_next;
            rd_idx_reg     <= rd_idx_next;
            rd_pend_reg    <= rd_pend_next;
            cnt_reg        <= cnt_next;
            found_reg      <= found_next;
            stat_reg       <= stat_next;
            out_valid_reg  <= out_valid_next;
            res_status_reg <= res_status_next;
            res_count_reg  <= res_count_next;
            res_found_reg  <= res_found_next;
            res_length_reg <= res_length_next;
            res_head_reg   <= res_head_next;
            res_tail_reg   <= res_tail_next;
            res_empty_reg  <= res_empty_next;
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = res_status_reg;
    assign match_count = res_count_reg;
    assign found       = res_found_reg;
    assign list_length = res_length_reg;
    assign head_value  = res_head_reg;
    assign tail_value  = res_tail_reg;
    assign is_empty    = res_empty_reg;

    `BOLS_ASSERT_NEXT(a_accept_exec, clk, rst_n, in_valid && !in_stall,
        state_reg == S_EXEC, "accepted item did not start execution")
    `BOLS_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= CW'(DEPTH),
        "fill count beyond depth")
    `BOLS_ASSERT_NOW(a_scan_no_write, clk, rst_n, state_reg == S_SCAN, !mem_we,
        "memory written during scan")
    `BOLS_ASSERT_NEXT(a_erase_shrinks, clk, rst_n,
        state_reg == S_SHIFT && state_next == S_RDHEAD,
        fill_reg == $past(fill_reg) - CW'(1), "erase did not shrink list by one")
    `BOLS_ASSERT_NOW(a_count_bound, clk, rst_n, state_reg == S_FIN, cnt_reg <= fill_reg,
        "match count exceeds length")

endmodule

`default_nettype wire

[tb/bounded_ordered_list_store_core_tb.sv]
`timescale 1ns / 1ps

module bounded_ordered_list_store_core_tb;

    import bols_pkg::*;

    localparam int LIST_DEPTH    = 16;
    localparam int RANDOM_ITEMS  = 1575;
    localparam int PHASE_ITEMS   = 525;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 40;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int REPORT_MAX    = 10;

    // The two op codes the block treats as no-ops.
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [OUT_CNT_W-1:0] match_count;
        logic                 found;
        logic [OUT_CNT_W-1:0] list_length;
        logic [IO_VAL_W-1:0]  head_value;
        logic [IO_VAL_W-1:0]  tail_value;
        logic                 is_empty;
    } list_view_t;

    typedef struct {
        logic [OP_W-1:0]     code;
        logic [IO_VAL_W-1:0] val;
        logic [POS_W-1:0]    pos;
        int                  reps;
        bit                  has_view;
        list_view_t          view;
    } list_cmd_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [OP_W-1:0]      op;
    logic [IO_VAL_W-1:0]  item_value;
    logic [POS_W-1:0]     position;
    logic                 out_valid;
    logic                 out_stall;
    logic [STAT_W-1:0]    status;
    logic [OUT_CNT_W-1:0] match_count;
    logic                 found;
    logic [OUT_CNT_W-1:0] list_length;
    logic [IO_VAL_W-1:0]  head_value;
    logic [IO_VAL_W-1:0]  tail_value;
    logic                 is_empty;

    // Shadow copy of the list contents.
    logic [IO_VAL_W-1:0]  shadow_entries [LIST_DEPTH];
    logic [OUT_CNT_W-1:0] shadow_fill;

    list_view_t pending_views [$];
    list_cmd_t  directed_cmds [$];

    int mismatch_count;
    int views_checked;
    int op_tally [8];
    int full_drops;
    int misses;
    int sender_idle_pct;
    int receiver_stall_pct;
    int test_phase;
    bit held_off;

    bounded_ordered_list_store_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .item_value  (item_value),
        .position    (position),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .match_count (match_count),
        .found       (found),
        .list_length (list_length),
        .head_value  (head_value),
        .tail_value  (tail_value),
        .is_empty    (is_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Applies one operation to the shadow list and returns the view it reports.
    function automatic list_view_t apply_list_op(input logic [OP_W-1:0] code,
                                                 input logic [IO_VAL_W-1:0] val,
                                                 input logic [POS_W-1:0] pos);
        list_view_t           v;
        int                   hit;
        int                   k;
        logic [OUT_CNT_W-1:0] hits;
        v = '0;
        hit = -1;
        hits = '0;
        case (code)
            OP_APPEND:
            begin
                if (shadow_fill == LIST_DEPTH)
                    v.status = ST_FULL;
                else
                begin
                    shadow_entries[shadow_fill] = val;
                    shadow_fill = shadow_fill + 1'b1;
                end
            end
            OP_ERASE:
            begin
                if (shadow_fill == 0)
                    v.status = ST_EMPTY;
                else
                begin
                    for (k = 0; k < shadow_fill; k++)
                        if (hit < 0 && shadow_entries[k] == val)
                            hit = k;
                    if (hit < 0)
                        v.status = ST_MISS;
                    else
                    begin
                        v.found = 1'b1;
                        for (k = hit; k + 1 < shadow_fill; k++)
                            shadow_entries[k] = shadow_entries[k + 1];
                        shadow_fill = shadow_fill - 1'b1;
                    end
                end
            end
            OP_SET:
            begin
                if (pos < shadow_fill)
                    shadow_entries[pos] = val;
                else
                    v.status = ST_MISS;
            end
            OP_COUNT, OP_CONTAINS:
            begin
                if (shadow_fill == 0)
                    v.status = ST_EMPTY;
                else
                begin
                    for (k = 0; k < shadow_fill; k++)
                        if (shadow_entries[k] == val)
                            hits = hits + 1'b1;
                    v.found = (hits != 0);
                    if (code == OP_COUNT)
                        v.match_count = hits;
                end
            end
            OP_CLEAR:
                shadow_fill = '0;
            default:
                ;
        endcase
        v.list_length = shadow_fill;
        v.is_empty    = (shadow_fill == 0);
        if (shadow_fill != 0)
        begin
            v.head_value = shadow_entries[0];
            v.tail_value = shadow_entries[shadow_fill - 1];
        end
        return v;
    endfunction

    function automatic list_cmd_t list_cmd(input logic [OP_W-1:0] code,
                                           input logic [IO_VAL_W-1:0] val,
                                           input logic [POS_W-1:0] pos, input int reps,
                                           input bit has_view, input list_view_t view);
        list_cmd_t c;
        c.code     = code;
        c.val      = val;
        c.pos      = pos;
        c.reps     = reps;
        c.has_view = has_view;
        c.view     = view;
        return c;
    endfunction

    // Adds one row to the end of the directed table.
    function automatic void queue_cmd(input list_cmd_t c);
        directed_cmds = {directed_cmds, c};
    endfunction

    // Offers one item, waits for it to be taken and records the view it must produce.
    task automatic send_list_op(input logic [OP_W-1:0] code, input logic [IO_VAL_W-1:0] val,
                                input logic [POS_W-1:0] pos, input bit has_view,
                                input list_view_t view);
        list_view_t predicted;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        op         <= code;
        item_value <= val;
        position   <= pos;
        do
            @(posedge clk);
        while (in_stall);
        predicted = apply_list_op(code, val, pos);
        pending_views = {pending_views, (has_view ? view : predicted)};
        op_tally[code]++;
        if (predicted.status == ST_FULL)
            full_drops++;
        if (predicted.status == ST_MISS)
            misses++;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        list_view_t got;
        list_view_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{status, match_count, found, list_length, head_value, tail_value, is_empty};
            if (pending_views.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("[%0t] result with no item outstanding: %p", $realtime, got);
            end
            else
            begin
                want = pending_views.pop_front();
                views_checked++;
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                    begin
                        $display("[%0t] mismatch on result %0d", $realtime, views_checked);
                        $display("    status      exp %0d got %0d", want.status, got.status);
                        $display("    match_count exp %0d got %0d",
                                 want.match_count, got.match_count);
                        $display("    found       exp %0d got %0d", want.found, got.found);
                        $display("    list_length exp %0d got %0d",
                                 want.list_length, got.list_length);
                        $display("    head_value  exp %h got %h",
                                 want.head_value, got.head_value);
                        $display("    tail_value  exp %h got %h",
                                 want.tail_value, got.tail_value);
                        $display("    is_empty    exp %0d got %0d", want.is_empty, got.is_empty);
                    end
                end
            end
        end
    end

    // Receiver side, including one long hold-off once the last phase begins.
    initial
    begin
        out_stall = 1'b0;
        held_off  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (test_phase == 3 && !held_off)
            begin
                held_off = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
                out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Ends the run when neither channel moves for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_MAX)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[%0t] no handshake for %0d cycles", $realtime, WATCHDOG_MAX);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        list_cmd_t            c;
        logic [OP_W-1:0]      code;
        logic [IO_VAL_W-1:0]  val;
        logic [POS_W-1:0]     pos;
        logic [IO_VAL_W-1:0]  value_pool [4];
        int                   grow_bias;
        int                   r;
        int                   sel;
        int                   i;
        int                   n;

        rst_n              = 1'b0;
        in_valid           = 1'b0;
        op                 = OP_APPEND;
        item_value         = '0;
        position           = '0;
        shadow_fill        = '0;
        mismatch_count     = 0;
        views_checked      = 0;
        full_drops         = 0;
        misses             = 0;
        test_phase         = 1;
        sender_idle_pct    = 28;
        receiver_stall_pct = 60;
        grow_bias          = 40;
        foreach (op_tally[k])
            op_tally[k] = 0;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h0000_0001;

        // Empty list corner cases first, then erases at both ends of a short list, then a full list.
        queue_cmd(list_cmd(OP_COUNT, 32'h0, 4'd0, 1, 1'b1,
            '{ST_EMPTY, 5'd0, 1'b0, 5'd0, 32'h0, 32'h0, 1'b1}));
        queue_cmd(list_cmd(OP_ERASE, 32'hFFFF_FFFF, 4'd0, 1, 1'b1,
            '{ST_EMPTY, 5'd0, 1'b0, 5'd0, 32'h0, 32'h0, 1'b1}));
        queue_cmd(list_cmd(OP_CONTAINS, 32'h0, 4'd15, 1, 1'b1,
            '{ST_EMPTY, 5'd0, 1'b0, 5'd0, 32'h0, 32'h0, 1'b1}));
        queue_cmd(list_cmd(OP_SET, 32'h1, 4'd0, 1, 1'b1,
            '{ST_MISS, 5'd0, 1'b0, 5'd0, 32'h0, 32'h0, 1'b1}));
        queue_cmd(list_cmd(OP_SPARE_A, 32'hFFFF_FFFF, 4'd15, 1, 1'b1,
            '{ST_OK, 5'd0, 1'b0, 5'd0, 32'h0, 32'h0, 1'b1}));
        queue_cmd(list_cmd(OP_CLEAR, 32'h0, 4'd0, 1, 1'b1,
            '{ST_OK, 5'd0, 1'b0, 5'd0, 32'h0, 32'h0, 1'b1}));
        queue_cmd(list_cmd(OP_APPEND, 32'hFFFF_FFFF, 4'd0, 1, 1'b1,
            '{ST_OK, 5'd0, 1'b0, 5'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0}));
        queue_cmd(list_cmd(OP_APPEND, 32'h0, 4'd0, 1, 1'b1,
            '{ST_OK, 5'd0, 1'b0, 5'd2, 32'hFFFF_FFFF, 32'h0, 1'b0}));
        queue_cmd(list_cmd(OP_SET, 32'h1234_5678, 4'd2, 1, 1'b1,
            '{ST_MISS, 5'd0, 1'b0, 5'd2, 32'hFFFF_FFFF, 32'h0, 1'b0}));
        queue_cmd(list_cmd(OP_SET, 32'h1234_5678, 4'd15, 1, 1'b1,
            '{ST_MISS, 5'd0, 1'b0, 5'd2, 32'hFFFF_FFFF, 32'h0, 1'b0}));
        queue_cmd(list_cmd(OP_CONTAINS, 32'h0, 4'd0, 1, 1'b1,
            '{ST_OK, 5'd0, 1'b1, 5'd2, 32'hFFFF_FFFF, 32'h0, 1'b0}));
        queue_cmd(list_cmd(OP_CONTAINS, 32'h1234_5678, 4'd0, 1, 1'b0, '0));
        queue_cmd(list_cmd(OP_COUNT, 32'hFFFF_FFFF, 4'd0, 1, 1'b0, '0));
        queue_cmd(list_cmd(OP_ERASE, 32'h1234_5678, 4'd0, 1, 1'b0, '0));
        queue_cmd(list_cmd(OP_ERASE, 32'hFFFF_FFFF, 4'd0, 1, 1'b0, '0));
        queue_cmd(list_cmd(OP_ERASE, 32'h0, 4'd0, 1, 1'b1,
            '{ST_OK, 5'd0, 1'b1, 5'd0, 32'h0, 32'h0, 1'b1}));
        queue_cmd(list_cmd(OP_APPEND, 32'hA5A5_A5A5, 4'd0, LIST_DEPTH, 1'b0,
            '0));
        queue_cmd(list_cmd(OP_APPEND, 32'h0, 4'd0, 1, 1'b1,
            '{ST_FULL, 5'd0, 1'b0, 5'd16, 32'hA5A5_A5A5, 32'hA5A5_A5A5, 1'b0}));
        queue_cmd(list_cmd(OP_COUNT, 32'hA5A5_A5A5, 4'd0, 1, 1'b1,
            '{ST_OK, 5'd16, 1'b1, 5'd16, 32'hA5A5_A5A5, 32'hA5A5_A5A5, 1'b0}));
        queue_cmd(list_cmd(OP_SET, 32'h0, 4'd15, 1, 1'b1,
            '{ST_OK, 5'd0, 1'b0, 5'd16, 32'hA5A5_A5A5, 32'h0, 1'b0}));
        queue_cmd(list_cmd(OP_SET, 32'hFFFF_FFFF, 4'd0, 1, 1'b1,
            '{ST_OK, 5'd0, 1'b0, 5'd16, 32'hFFFF_FFFF, 32'h0, 1'b0}));
        queue_cmd(list_cmd(OP_SET, 32'h5A5A_5A5A, 4'd7, 1, 1'b0, '0));
        queue_cmd(list_cmd(OP_CONTAINS, 32'h5A5A_5A5A, 4'd0, 1, 1'b0, '0));
        queue_cmd(list_cmd(OP_ERASE, 32'hA5A5_A5A5, 4'd0, 1, 1'b0, '0));
        // Erasing the last entry must move the reported tail back by one.
        queue_cmd(list_cmd(OP_ERASE, 32'h0, 4'd0, 1, 1'b0, '0));
        queue_cmd(list_cmd(OP_SPARE_B, 32'h0, 4'd0, 1, 1'b0, '0));
        queue_cmd(list_cmd(OP_CLEAR, 32'hFFFF_FFFF, 4'd15, 1, 1'b1,
            '{ST_OK, 5'd0, 1'b0, 5'd0, 32'h0, 32'h0, 1'b1}));

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_cmds[k])
        begin
            c = directed_cmds[k];
            for (n = 0; n < c.reps; n++)
                send_list_op(c.code, c.val, c.pos, c.has_view, c.view);
        end

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == PHASE_ITEMS)
            begin
                test_phase         = 2;
                sender_idle_pct    = 60;
                receiver_stall_pct = 28;
            end
            else if (i == 2 * PHASE_ITEMS)
            begin
                test_phase         = 3;
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            // Swing between growing and shrinking so the list visits empty and full.
            if (i % 64 == 0)
                grow_bias = $urandom_range(70, 15);

            r = $urandom_range(grow_bias + 63);
            if (r < grow_bias)
                code = OP_APPEND;
            else
            begin
                r = r - grow_bias;
                if (r < 25)
                    code = OP_ERASE;
                else if (r < 40)
                    code = OP_SET;
                else if (r < 50)
                    code = OP_COUNT;
                else if (r < 60)
                    code = OP_CONTAINS;
                else if (r < 62)
                    code = OP_CLEAR;
                else if (r == 62)
                    code = OP_SPARE_A;
                else
                    code = OP_SPARE_B;
            end

            sel = $urandom_range(99);
            if (sel < 35 && shadow_fill != 0)
                val = shadow_entries[$urandom_range(shadow_fill - 1)];
            else if (sel < 65)
                val = value_pool[$urandom_range(3)];
            else if (sel < 75)
                val = $urandom_range(7);
            else
                val = $urandom();

            if ($urandom_range(99) < 70 && shadow_fill != 0)
                pos = POS_W'($urandom_range(shadow_fill - 1));
            else
                pos = POS_W'($urandom_range(15));

            send_list_op(code, val, pos, 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d items: %0d append, %0d erase, %0d set, %0d count, %0d contains,",
                 views_checked, op_tally[OP_APPEND], op_tally[OP_ERASE], op_tally[OP_SET],
                 op_tally[OP_COUNT], op_tally[OP_CONTAINS]);
        $display("%0d clear, %0d unused op; %0d full drops, %0d misses, %0d mismatches.",
                 op_tally[OP_CLEAR], op_tally[OP_SPARE_A] + op_tally[OP_SPARE_B],
                 full_drops, misses, mismatch_count);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
